// ----- hw/rtl/cdc_pkg.sv -----
package cdc_pkg;

    localparam int CNT_W    = 7;
    localparam int PADDR_W  = 4;
    localparam int DEF_MAX_IN_CH    = 16;
    localparam int DEF_MAX_OUT_CH   = 16;
    localparam int DEF_MAX_TAPS     = 8;
    localparam int DEF_MAX_DILATION = 16;
    localparam int DEF_HIST_DEPTH   = 128;
    localparam int ACC_W    = 48;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_WEIGHT = 2'd1;
    localparam logic [1:0] OP_BIAS   = 2'd2;

    localparam logic [1:0] REG_IN_CH  = 2'd0;
    localparam logic [1:0] REG_OUT_CH = 2'd1;
    localparam logic [1:0] REG_TAPS   = 2'd2;
    localparam logic [1:0] REG_DIL    = 2'd3;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_WEIGHT,
        CMD_BIAS
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic         wr_en;
        logic         ends_step;
        logic         seq_start;
        logic [3:0]   out_index;
        logic [3:0]   in_index;
        logic [2:0]   tap_index;
        logic [31:0]  data;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] ic;
        logic [CNT_W-1:0] oc;
        logic [CNT_W-1:0] taps;
        logic [CNT_W-1:0] dil;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  channel;
        logic [31:0] value;
        logic        last;
    } t_res;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_BIAS,
        BS_INIT,
        BS_ISSUE,
        BS_DRAIN,
        BS_WRITE
    } t_bstate;

    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [4:0] v, input int hi);
        logic [CNT_W-1:0] r;
        if (v == 5'd0) begin
            r = CNT_W'(1);
        end else if (32'(v) > hi) begin
            r = CNT_W'(hi);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] a);
        logic [31:0] r;
        if (a > ACC_W'(64'sh7FFF_FFFF)) begin
            r = 32'h7FFF_FFFF;
        end else if (a < -ACC_W'(64'sh8000_0000)) begin
            r = 32'h8000_0000;
        end else begin
            r = a[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/cdc_ram.sv -----
module cdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hw/rtl/cdc_fifo.sv -----
module cdc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full   = (r_cnt == CW'(DEPTH));
    assign o_empty  = (r_cnt == '0);
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && !o_empty;
    assign o_data   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule

// ----- hw/rtl/cdc_front.sv -----
module cdc_front #(
    parameter int MAX_IN_CH  = cdc_pkg::DEF_MAX_IN_CH,
    parameter int MAX_OUT_CH = cdc_pkg::DEF_MAX_OUT_CH,
    parameter int MAX_TAPS   = cdc_pkg::DEF_MAX_TAPS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cdc_pkg::t_cfg i_cfg,
    input  logic          i_push,
    output logic          o_full,
    input  logic [1:0]    i_operation,
    input  logic [3:0]    i_out_index,
    input  logic [3:0]    i_in_index,
    input  logic [2:0]    i_tap_index,
    input  logic [15:0]   i_sample_value,
    input  logic [15:0]   i_weight_value,
    input  logic [31:0]   i_bias_value,
    input  logic          i_sequence_start,
    output cdc_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);
    cdc_pkg::t_cmd cmd;
    logic          keep;
    logic          cmd_empty;
    logic          in_ok, out_ok, tap_ok;

    assign in_ok  = 32'(i_in_index) < MAX_IN_CH;
    assign out_ok = 32'(i_out_index) < MAX_OUT_CH;
    assign tap_ok = 32'(i_tap_index) < MAX_TAPS;

    // classify the request; drop unknown operations and loads out of range
    always_comb begin
        cmd           = '0;
        keep          = 1'b0;
        cmd.out_index = i_out_index;
        cmd.in_index  = i_in_index;
        cmd.tap_index = i_tap_index;
        cmd.seq_start = i_sequence_start;
        case (i_operation)
            cdc_pkg::OP_SAMPLE: begin
                cmd.kind      = cdc_pkg::CMD_SAMPLE;
                cmd.data      = {{16{i_sample_value[15]}}, i_sample_value};
                cmd.wr_en     = in_ok;
                cmd.ends_step = (cdc_pkg::CNT_W'(i_in_index)
                                 == i_cfg.ic - cdc_pkg::CNT_W'(1));
                keep          = 1'b1;
            end
            cdc_pkg::OP_WEIGHT: begin
                cmd.kind  = cdc_pkg::CMD_WEIGHT;
                cmd.data  = {{16{i_weight_value[15]}}, i_weight_value};
                cmd.wr_en = 1'b1;
                keep      = in_ok && out_ok && tap_ok;
            end
            cdc_pkg::OP_BIAS: begin
                cmd.kind  = cdc_pkg::CMD_BIAS;
                cmd.data  = i_bias_value;
                cmd.wr_en = 1'b1;
                keep      = out_ok;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    cdc_fifo #(
        .WIDTH ($bits(cdc_pkg::t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && keep),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (cmd_empty)
    );

    assign o_cmd_valid = !cmd_empty;
endmodule

// ----- hw/rtl/cdc_back.sv -----
module cdc_back #(
    parameter int MAX_IN_CH    = cdc_pkg::DEF_MAX_IN_CH,
    parameter int MAX_OUT_CH   = cdc_pkg::DEF_MAX_OUT_CH,
    parameter int MAX_TAPS     = cdc_pkg::DEF_MAX_TAPS,
    parameter int MAX_DILATION = cdc_pkg::DEF_MAX_DILATION,
    parameter int HIST_DEPTH   = cdc_pkg::DEF_HIST_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cdc_pkg::t_cfg i_cfg,
    input  cdc_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    output cdc_pkg::t_res o_res,
    output logic          o_res_empty,
    input  logic          i_res_pop
);
    localparam int OW    = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int IW    = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
    localparam int KW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int SW    = $clog2(HIST_DEPTH);
    localparam int HA_W  = (HIST_DEPTH * MAX_IN_CH > 1) ? $clog2(HIST_DEPTH * MAX_IN_CH) : 1;
    localparam int WD    = MAX_OUT_CH * MAX_IN_CH * MAX_TAPS;
    localparam int WA_W  = (WD > 1) ? $clog2(WD) : 1;
    localparam int OFF_W = KW + cdc_pkg::CNT_W;
    localparam int CW    = cdc_pkg::CNT_W;
    localparam int AW    = cdc_pkg::ACC_W;

    cdc_pkg::t_bstate r_state, n_state;
    logic [OW-1:0]    r_o, n_o;
    logic [IW-1:0]    r_i, n_i;
    logic [KW-1:0]    r_k, n_k;
    logic [SW-1:0]    r_ptr, n_ptr;
    logic [SW-1:0]    r_steps, n_steps;
    logic signed [AW-1:0] r_acc;
    logic             r_p1_v, r_p1_use, r_p2_v, r_p2_use;
    logic signed [31:0] r_prod;
    logic             issue, init;

    logic             h_we, w_we, b_we;
    logic [HA_W-1:0]  h_waddr, h_raddr;
    logic [WA_W-1:0]  w_waddr, w_raddr;
    logic [OW-1:0]    b_waddr;
    logic [15:0]      h_rdata, w_rdata;
    logic [31:0]      b_rdata;
    logic [OFF_W-1:0] off;
    logic [SW-1:0]    off_s;
    logic [SW-1:0]    slot;
    logic             use_tap;
    logic             res_push, res_full;
    cdc_pkg::t_res    res;
    logic             last_o;

    assign off     = OFF_W'(r_k) * OFF_W'(i_cfg.dil);
    assign off_s   = off[SW-1:0];
    assign use_tap = (32'(off) <= 32'(r_steps)) && (32'(off) < HIST_DEPTH);
    assign slot    = (r_ptr >= off_s) ? r_ptr - off_s
                   : SW'((SW+1)'(r_ptr) + (SW+1)'(HIST_DEPTH) - (SW+1)'(off_s));

    assign h_waddr = HA_W'(r_ptr) * HA_W'(MAX_IN_CH) + HA_W'(i_cmd.in_index);
    assign h_raddr = HA_W'(slot) * HA_W'(MAX_IN_CH) + HA_W'(r_i);
    assign w_waddr = (WA_W'(i_cmd.out_index) * WA_W'(MAX_IN_CH) + WA_W'(i_cmd.in_index))
                     * WA_W'(MAX_TAPS) + WA_W'(i_cmd.tap_index);
    assign w_raddr = (WA_W'(r_o) * WA_W'(MAX_IN_CH) + WA_W'(r_i)) * WA_W'(MAX_TAPS)
                     + WA_W'(r_k);
    assign b_waddr = OW'(i_cmd.out_index);
    assign last_o  = (CW'(r_o) == i_cfg.oc - CW'(1));

    assign res.channel = 4'(r_o);
    assign res.value   = cdc_pkg::sat32(r_acc);
    assign res.last    = last_o;

    always_comb begin
        n_state   = r_state;
        n_o       = r_o;
        n_i       = r_i;
        n_k       = r_k;
        n_ptr     = r_ptr;
        n_steps   = r_steps;
        o_cmd_pop = 1'b0;
        h_we      = 1'b0;
        w_we      = 1'b0;
        b_we      = 1'b0;
        issue     = 1'b0;
        init      = 1'b0;
        res_push  = 1'b0;
        case (r_state)
            cdc_pkg::BS_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        cdc_pkg::CMD_WEIGHT: w_we = 1'b1;
                        cdc_pkg::CMD_BIAS:   b_we = 1'b1;
                        cdc_pkg::CMD_SAMPLE: begin
                            h_we = i_cmd.wr_en;
                            if (i_cmd.seq_start) begin
                                n_steps = '0;
                            end
                            if (i_cmd.ends_step) begin
                                n_o     = '0;
                                n_state = cdc_pkg::BS_BIAS;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            cdc_pkg::BS_BIAS: begin
                n_state = cdc_pkg::BS_INIT;
            end
            cdc_pkg::BS_INIT: begin
                init    = 1'b1;
                n_i     = '0;
                n_k     = '0;
                n_state = cdc_pkg::BS_ISSUE;
            end
            cdc_pkg::BS_ISSUE: begin
                issue = 1'b1;
                if (CW'(r_k) == i_cfg.taps - CW'(1)) begin
                    n_k = '0;
                    if (CW'(r_i) == i_cfg.ic - CW'(1)) begin
                        n_state = cdc_pkg::BS_DRAIN;
                    end else begin
                        n_i = r_i + IW'(1);
                    end
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            cdc_pkg::BS_DRAIN: begin
                if (!r_p1_v && !r_p2_v) begin
                    n_state = cdc_pkg::BS_WRITE;
                end
            end
            cdc_pkg::BS_WRITE: begin
                if (!res_full) begin
                    res_push = 1'b1;
                    if (last_o) begin
                        // step done: advance history
                        n_ptr   = (r_ptr == SW'(HIST_DEPTH - 1)) ? '0 : r_ptr + SW'(1);
                        n_steps = (r_steps == SW'(HIST_DEPTH - 1)) ? r_steps
                                  : r_steps + SW'(1);
                        n_state = cdc_pkg::BS_IDLE;
                    end else begin
                        n_o     = r_o + OW'(1);
                        n_state = cdc_pkg::BS_BIAS;
                    end
                end
            end
            default: begin
                n_state = cdc_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cdc_pkg::BS_IDLE;
            r_o      <= '0;
            r_i      <= '0;
            r_k      <= '0;
            r_ptr    <= '0;
            r_steps  <= '0;
            r_p1_v   <= 1'b0;
            r_p2_v   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_o      <= n_o;
            r_i      <= n_i;
            r_k      <= n_k;
            r_ptr    <= n_ptr;
            r_steps  <= n_steps;
            r_p1_v   <= issue;
            r_p2_v   <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_use <= use_tap;
        r_p2_use <= r_p1_use;
        r_prod   <= $signed(w_rdata) * $signed(h_rdata);
        if (init) begin
            r_acc <= AW'($signed(b_rdata));
        end else if (r_p2_v && r_p2_use) begin
            r_acc <= r_acc + AW'(r_prod);
        end
    end

    cdc_ram #(.WIDTH(16), .DEPTH(HIST_DEPTH * MAX_IN_CH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (i_cmd.data[15:0]),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    cdc_ram #(.WIDTH(16), .DEPTH(WD)) u_weight (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_cmd.data[15:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    cdc_ram #(.WIDTH(32), .DEPTH(MAX_OUT_CH)) u_bias (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (i_cmd.data),
        .i_raddr (r_o),
        .o_rdata (b_rdata)
    );

    cdc_fifo #(
        .WIDTH ($bits(cdc_pkg::t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_res_pop),
        .o_data  (o_res),
        .o_empty (o_res_empty)
    );

`ifndef SYNTH
    a_p2_follows_p1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p2_v && $past(i_rst_n)) |-> $past(r_p1_v))
        else $error("product stage without a read");

    a_write_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdc_pkg::BS_WRITE) |-> (!r_p1_v && !r_p2_v))
        else $error("result written with products in flight");

    a_drain_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdc_pkg::BS_DRAIN && $past(i_rst_n))
        |-> ($past(r_state) == cdc_pkg::BS_ISSUE || $past(r_state) == cdc_pkg::BS_DRAIN))
        else $error("drain entered without issue");

    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_ptr != $past(r_ptr)) |-> ($past(r_state) == cdc_pkg::BS_WRITE))
        else $error("history pointer moved outside a step end");
`endif
endmodule

// ----- hw/rtl/causal_dilated_conv1d_core.sv -----
// Load requests are queued and written to their table once the idle back end pops them.
// A step-ending sample: per output channel the bias is read and loaded, products are issued
// by the single multiply-accumulate unit reading one weight and one history word per cycle,
// the pipeline drains and the result is queued; no command is taken until the step ends.
// Reset (i_rst_n, synchronous, active low) clears queues, pointers, control state and
// configuration registers to their defaults; weight, bias and history memories hold garbage until written.
module causal_dilated_conv1d_core #(
    parameter int MAX_IN_CH    = cdc_pkg::DEF_MAX_IN_CH,
    parameter int MAX_OUT_CH   = cdc_pkg::DEF_MAX_OUT_CH,
    parameter int MAX_TAPS     = cdc_pkg::DEF_MAX_TAPS,
    parameter int MAX_DILATION = cdc_pkg::DEF_MAX_DILATION,
    parameter int HIST_DEPTH   = cdc_pkg::DEF_HIST_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cdc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_operation,
    input  logic [3:0]                  i_out_index,
    input  logic [3:0]                  i_in_index,
    input  logic [2:0]                  i_tap_index,
    input  logic [15:0]                 i_sample_value,
    input  logic [15:0]                 i_weight_value,
    input  logic [31:0]                 i_bias_value,
    input  logic                        i_sequence_start,
    output logic                        empty,
    input  logic                        pop,
    output logic [3:0]                  o_out_channel,
    output logic [31:0]                 o_out_value,
    output logic                        o_last
);
    logic [4:0]    r_in_ch, r_out_ch, r_dil;
    logic [3:0]    r_taps;
    cdc_pkg::t_cfg cfg;
    cdc_pkg::t_cmd cmd;
    logic          cmd_valid, cmd_pop;
    cdc_pkg::t_res res;
    logic          wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ch  <= 5'd1;
            r_out_ch <= 5'd1;
            r_taps   <= 4'd1;
            r_dil    <= 5'd1;
        end else if (wr) begin
            case (paddr[3:2])
                cdc_pkg::REG_IN_CH:  r_in_ch  <= pwdata[4:0];
                cdc_pkg::REG_OUT_CH: r_out_ch <= pwdata[4:0];
                cdc_pkg::REG_TAPS:   r_taps   <= pwdata[3:0];
                cdc_pkg::REG_DIL:    r_dil    <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            cdc_pkg::REG_IN_CH:  prdata = {27'd0, r_in_ch};
            cdc_pkg::REG_OUT_CH: prdata = {27'd0, r_out_ch};
            cdc_pkg::REG_TAPS:   prdata = {28'd0, r_taps};
            cdc_pkg::REG_DIL:    prdata = {27'd0, r_dil};
            default:             prdata = '0;
        endcase
    end

    // zero counts as one, values above the maximum are held at it
    assign cfg.ic   = cdc_pkg::clamp_cnt(r_in_ch, MAX_IN_CH);
    assign cfg.oc   = cdc_pkg::clamp_cnt(r_out_ch, MAX_OUT_CH);
    assign cfg.taps = cdc_pkg::clamp_cnt({1'b0, r_taps}, MAX_TAPS);
    assign cfg.dil  = cdc_pkg::clamp_cnt(r_dil, MAX_DILATION);

    cdc_front #(
        .MAX_IN_CH  (MAX_IN_CH),
        .MAX_OUT_CH (MAX_OUT_CH),
        .MAX_TAPS   (MAX_TAPS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_push           (push),
        .o_full           (full),
        .i_operation      (i_operation),
        .i_out_index      (i_out_index),
        .i_in_index       (i_in_index),
        .i_tap_index      (i_tap_index),
        .i_sample_value   (i_sample_value),
        .i_weight_value   (i_weight_value),
        .i_bias_value     (i_bias_value),
        .i_sequence_start (i_sequence_start),
        .o_cmd            (cmd),
        .o_cmd_valid      (cmd_valid),
        .i_cmd_pop        (cmd_pop)
    );

    cdc_back #(
        .MAX_IN_CH    (MAX_IN_CH),
        .MAX_OUT_CH   (MAX_OUT_CH),
        .MAX_TAPS     (MAX_TAPS),
        .MAX_DILATION (MAX_DILATION),
        .HIST_DEPTH   (HIST_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res),
        .o_res_empty (empty),
        .i_res_pop   (pop)
    );

    assign o_out_channel = res.channel;
    assign o_out_value   = res.value;
    assign o_last        = res.last;
endmodule
